// File: rtl/pfa_pkg.sv
// Package for the page frame allocator: pool geometry, codes, payload and control types.
// Used by every module of the block but pfa_ram; depends on nothing.
package pfa_pkg;

    localparam int POOL_FRAMES     = 256;
    localparam int POOL_BASE_FRAME = 768;
    localparam int PAGE_SHIFT      = 12;

    localparam int ROW_BITS = 32;
    localparam int BIT_W    = 5;
    localparam int ROWS     = (POOL_FRAMES + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W   = ROW_AW + BIT_W;

    localparam logic [31:0] POOL_BASE32 = 32'(POOL_BASE_FRAME);
    localparam logic [31:0] POOL_END32  = 32'(POOL_BASE_FRAME + POOL_FRAMES);

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOMEM       = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_OUTSIDE     = 2'd3
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] page_addr;
    } pfa_in_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] alloc_addr;
    } pfa_out_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_CHECK,
        FSM_MODIFY,
        FSM_RESP
    } fsm_state_t;

    typedef struct packed {
        logic ready;
        logic check;
        logic modify;
        logic load_out;
    } pfa_ctrl_t;

    // Bits of a bitmap row that lie beyond the end of the pool; they always read as used.
    function automatic logic [ROW_BITS-1:0] pad_mask(input logic [ROW_AW-1:0] row);
        int                  first;
        logic [ROW_BITS-1:0] m;
        first = int'(row) * ROW_BITS;
        for (int b = 0; b < ROW_BITS; b++) begin
            m[b] = ((first + b) >= POOL_FRAMES);
        end
        return m;
    endfunction

endpackage

// File: rtl/pfa_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package dependencies.
module pfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pfa_ctrl.sv
// Request sequencer of the page frame allocator: capture, check, read-modify-write, respond.
// Depends on pfa_pkg.
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      out_free,
    input  logic      skip,
    output pfa_ctrl_t ctrl
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    state_next = FSM_CHECK;
                end
            end
            FSM_CHECK: begin
                state_next = skip ? FSM_RESP : FSM_MODIFY;
            end
            FSM_MODIFY: begin
                state_next = FSM_RESP;
            end
            FSM_RESP: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            FSM_IDLE:   ctrl.ready    = 1'b1;
            FSM_CHECK:  ctrl.check    = 1'b1;
            FSM_MODIFY: ctrl.modify   = 1'b1;
            FSM_RESP:   ctrl.load_out = out_free;
            default:    ctrl          = '0;
        endcase
    end

endmodule

// File: rtl/pfa_map.sv
// Frame occupancy store: bitmap RAM, per-row valid and full flags, search and update.
// Depends on pfa_pkg and pfa_ram.
module pfa_map
    import pfa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  pfa_ctrl_t ctrl,
    input  pfa_in_t   req,
    output logic      skip,
    output pfa_out_t  result
);

    logic [ROWS-1:0]     row_valid_reg;
    logic [ROWS-1:0]     row_full_reg;
    logic [ROW_AW-1:0]   row_reg;
    logic [BIT_W-1:0]    bit_reg;
    pfa_out_t            res_reg;

    logic                any_free;
    logic [ROW_AW-1:0]   free_row;
    logic [31:0]         frame32;
    logic [31:0]         slot32;
    logic                in_pool;
    logic [SLOT_W-1:0]   slot;
    logic [ROW_AW-1:0]   sel_row;
    logic [BIT_W-1:0]    sel_bit;

    logic [ROW_BITS-1:0] rdata;
    logic [ROW_BITS-1:0] row_data;
    logic [ROW_BITS-1:0] pad;
    logic [ROW_BITS-1:0] occ;
    logic [BIT_W-1:0]    free_bit;
    logic [ROW_BITS-1:0] new_data;
    logic                new_full;
    logic [31:0]         frame_sum;
    pfa_out_t            mod_res;

    always_comb begin
        any_free = ~&row_full_reg;
        free_row = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (!row_full_reg[r]) begin
                free_row = ROW_AW'(r);
            end
        end
    end

    assign frame32 = req.page_addr >> PAGE_SHIFT;
    assign in_pool = (frame32 >= POOL_BASE32) && (frame32 < POOL_END32);
    assign slot32  = frame32 - POOL_BASE32;
    assign slot    = slot32[SLOT_W-1:0];

    assign sel_row = (req.kind == KIND_ALLOC) ? free_row : slot[SLOT_W-1:BIT_W];
    assign sel_bit = slot[BIT_W-1:0];
    assign skip    = (req.kind == KIND_ALLOC) ? !any_free : !in_pool;

    pfa_ram #(
        .WIDTH(ROW_BITS),
        .DEPTH(ROWS)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ctrl.modify),
        .waddr (row_reg),
        .wdata (new_data),
        .re    (ctrl.check && !skip),
        .raddr (sel_row),
        .rdata (rdata)
    );

    always_comb begin
        row_data = row_valid_reg[row_reg] ? rdata : '0;
        pad      = pad_mask(row_reg);
        occ      = row_data | pad;
        free_bit = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--) begin
            if (!occ[b]) begin
                free_bit = BIT_W'(b);
            end
        end
        frame_sum = POOL_BASE32 + 32'({row_reg, free_bit});
        mod_res   = '0;
        if (req.kind == KIND_ALLOC) begin
            new_data           = row_data | (ROW_BITS'(1) << free_bit);
            mod_res.status     = ST_OK;
            mod_res.alloc_addr = frame_sum << PAGE_SHIFT;
        end else begin
            new_data       = row_data & ~(ROW_BITS'(1) << bit_reg);
            mod_res.status = row_data[bit_reg] ? ST_OK : ST_DOUBLE_FREE;
        end
        new_full = &(new_data | pad);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            row_full_reg  <= '0;
        end else if (ctrl.modify) begin
            row_valid_reg[row_reg] <= 1'b1;
            row_full_reg[row_reg]  <= new_full;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.check) begin
            row_reg           <= sel_row;
            bit_reg           <= sel_bit;
            res_reg.status    <= (req.kind == KIND_ALLOC) ? ST_NOMEM : ST_OUTSIDE;
            res_reg.alloc_addr <= '0;
        end else if (ctrl.modify) begin
            res_reg <= mod_res;
        end
    end

    assign result = res_reg;

endmodule

// File: rtl/page_frame_allocator_unit.sv
// Page frame allocator: a pool of page frames with a reference count each, served one request
// at a time; the top level holds the request and result registers.
// Depends on pfa_pkg, pfa_ctrl, pfa_map and pfa_ram.
//
// A request is held from its transfer, and when it touches the occupancy bitmap its result
// passes the row search or pool range check with the bitmap RAM read, the write back, and the
// result load, in that order. A request that is rejected early (pool exhausted or address
// outside the pool) skips the write back. The result load waits while the result channel is
// busy, and the block takes no new request before the result of the last one is loaded; the
// single bitmap RAM read-modify-write sets this. A new request is taken while the previous
// result still waits on the result channel. Since a count only ever moves between zero and
// one, each frame's count is kept as one bit in a RAM of 32-bit rows, with a full flag per
// row to find the lowest free frame. Per-row valid flags make the pool empty right after
// reset, so no clearing pass is needed.
module page_frame_allocator_unit
    import pfa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pfa_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pfa_out_t m_data
);

    pfa_ctrl_t ctrl;
    pfa_in_t   req_reg;
    logic      m_valid_reg;
    pfa_out_t  m_data_reg;
    logic      out_free;
    logic      skip;
    pfa_out_t  result;

    assign out_free = !m_valid_reg || m_ready;

    pfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .skip     (skip),
        .ctrl     (ctrl)
    );

    pfa_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .req     (req_reg),
        .skip    (skip),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (s_valid && ctrl.ready) begin
            req_reg <= s_data;
        end
        if (ctrl.load_out) begin
            m_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign s_ready = ctrl.ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/pfa_checker.sv
// Port-level checker for the page frame allocator, bound to the top level.
// Depends on pfa_pkg and page_frame_allocator_unit.
module pfa_checker
    import pfa_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input pfa_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input pfa_out_t m_data
);

    logic [31:0] res_frame;

    assign res_frame = m_data.alloc_addr >> PAGE_SHIFT;

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Requests are served one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in work");

    // Only a successful allocation carries an address.
    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.alloc_addr == 32'd0)
        else $error("address on a failed request");

    // An allocated address is page aligned and inside the pool.
    a_addr_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.alloc_addr != 32'd0 |->
            res_frame >= POOL_BASE32 && res_frame < POOL_END32 &&
            (m_data.alloc_addr & ((32'd1 << PAGE_SHIFT) - 32'd1)) == 32'd0)
        else $error("allocated address outside the pool");

    // No result is shown right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind page_frame_allocator_unit pfa_checker u_pfa_checker (.*);
